[rtl/ffra_pkg.sv]
// shared types and constants of the first-fit range allocator
`default_nettype none
package ffra_pkg;

    localparam int OFF_W  = 16;
    localparam int SIZE_W = 17;
    localparam int CFG_W  = 17;
    localparam int LIM_W  = 2 * CFG_W;

    localparam int FREE_SLOTS_DEF = 16;
    localparam int LIVE_SLOTS_DEF = 16;

    localparam logic [SIZE_W-1:0] ARENA_CAP  = SIZE_W'(1) << OFF_W;
    localparam logic [CFG_W-1:0]  RST_PAGE   = CFG_W'(4096);
    localparam logic [CFG_W-1:0]  RST_FRAMES = CFG_W'(16);

    typedef enum logic [2:0] {
        ST_OK,
        ST_ZERO,
        ST_PAGES,
        ST_NOFIT,
        ST_UNKNOWN,
        ST_FULL
    } t_status;

    typedef enum logic [1:0] {
        CFG_ARENA,
        CFG_PAGE,
        CFG_FRAMES
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIMIT,
        S_CHECK,
        S_LSCAN,
        S_LCHECK,
        S_FSCAN,
        S_DECIDE,
        S_DIV_FIRST,
        S_WAIT_FIRST,
        S_DIV_LAST,
        S_WAIT_LAST,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic    accept;
        logic    load_limit;
        logic    lscan_step;
        logic    fscan_step;
        logic    div_start;
        logic    div_last;
        logic    commit;
        logic    emit_err;
        t_status err_code;
    } t_ctl;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic too_many;
        logic lscan_last;
        logic fscan_last;
        logic hit;
        logic best;
        logic live_full;
        logic merge_ok;
        logic div_done;
    } t_sts;

endpackage
`default_nettype wire

[rtl/ffra_div.sv]
// restoring divider for page numbers, one quotient bit per cycle
`default_nettype none
module ffra_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ffra_pkg::OFF_W-1:0]  i_dividend,
    input  wire logic [ffra_pkg::CFG_W-1:0]  i_divisor,
    output logic      [ffra_pkg::OFF_W-1:0]  o_quotient,
    output logic                             o_done
);
    import ffra_pkg::*;

    localparam int CNT_W = $clog2(OFF_W);

    logic [CFG_W-1:0] r_rem;
    logic [OFF_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CFG_W:0]   n_trial;
    logic             n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[OFF_W-1]};
        n_ge    = n_trial >= {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(OFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? CFG_W'(n_trial - {1'b0, i_divisor}) : n_trial[CFG_W-1:0];
            r_quo <= {r_quo[OFF_W-2:0], n_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule
`default_nettype wire

[rtl/ffra_ctrl.sv]
// request sequencer of the allocator
`default_nettype none
module ffra_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ffra_pkg::t_sts i_sts,
    output ffra_pkg::t_ctl     o_ctl,
    output logic               o_busy
);
    import ffra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_LIMIT;
            end
            S_LIMIT: n_state = i_sts.is_free ? S_LSCAN : S_CHECK;
            S_CHECK: begin
                if (i_sts.size_zero || i_sts.too_many) n_state = S_IDLE;
                else n_state = S_FSCAN;
            end
            S_LSCAN: begin
                if (i_sts.lscan_last) n_state = S_LCHECK;
            end
            S_LCHECK: n_state = i_sts.hit ? S_FSCAN : S_IDLE;
            S_FSCAN: begin
                if (i_sts.fscan_last) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.is_free) begin
                    n_state = i_sts.merge_ok ? S_DIV_FIRST : S_IDLE;
                end else begin
                    n_state = (i_sts.best && !i_sts.live_full) ? S_DIV_FIRST : S_IDLE;
                end
            end
            S_DIV_FIRST: n_state = S_WAIT_FIRST;
            S_WAIT_FIRST: begin
                if (i_sts.div_done) n_state = S_DIV_LAST;
            end
            S_DIV_LAST: n_state = S_WAIT_LAST;
            S_WAIT_LAST: begin
                if (i_sts.div_done) n_state = S_COMMIT;
            end
            S_COMMIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl          = '0;
        o_ctl.err_code = ST_OK;
        unique case (r_state)
            S_IDLE: o_ctl.accept = i_start;
            S_LIMIT: o_ctl.load_limit = 1'b1;
            S_CHECK: begin
                if (i_sts.size_zero) begin
                    o_ctl.emit_err = 1'b1;
                    o_ctl.err_code = ST_ZERO;
                end else if (i_sts.too_many) begin
                    o_ctl.emit_err = 1'b1;
                    o_ctl.err_code = ST_PAGES;
                end
            end
            S_LSCAN: o_ctl.lscan_step = 1'b1;
            S_LCHECK: begin
                if (!i_sts.hit) begin
                    o_ctl.emit_err = 1'b1;
                    o_ctl.err_code = ST_UNKNOWN;
                end
            end
            S_FSCAN: o_ctl.fscan_step = 1'b1;
            S_DECIDE: begin
                if (i_sts.is_free) begin
                    if (!i_sts.merge_ok) begin
                        o_ctl.emit_err = 1'b1;
                        o_ctl.err_code = ST_FULL;
                    end
                end else if (!i_sts.best) begin
                    o_ctl.emit_err = 1'b1;
                    o_ctl.err_code = ST_NOFIT;
                end else if (i_sts.live_full) begin
                    o_ctl.emit_err = 1'b1;
                    o_ctl.err_code = ST_FULL;
                end
            end
            S_DIV_FIRST: o_ctl.div_start = 1'b1;
            S_WAIT_FIRST: o_ctl.div_last = 1'b0;
            S_DIV_LAST: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_last  = 1'b1;
            end
            S_WAIT_LAST: o_ctl.div_last = 1'b1;
            S_COMMIT: o_ctl.commit = 1'b1;
            default: o_ctl.err_code = ST_OK;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    a_no_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_ctl.div_start)
        else $error("divider started while idle");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_WAIT_FIRST || r_state == S_WAIT_LAST))
        else $error("divider finished outside a wait state");

    a_word_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.commit || o_ctl.emit_err) |=> (r_state == S_IDLE))
        else $error("word sent without returning to idle");

endmodule
`default_nettype wire

[rtl/ffra_dp.sv]
// range tables, scans, page arithmetic and result registers
`default_nettype none
module ffra_dp #(
    parameter int FREE_SLOTS = ffra_pkg::FREE_SLOTS_DEF,
    parameter int LIVE_SLOTS = ffra_pkg::LIVE_SLOTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ffra_pkg::t_ctl              i_ctl,
    output ffra_pkg::t_sts                   o_sts,
    input  wire logic                        i_cmd,
    input  wire logic [ffra_pkg::SIZE_W-1:0] i_request_size,
    input  wire logic [ffra_pkg::OFF_W-1:0]  i_block_offset,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [ffra_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                             o_valid,
    output logic [2:0]                       o_status,
    output logic [ffra_pkg::OFF_W-1:0]       o_granted_offset,
    output logic [ffra_pkg::OFF_W-1:0]       o_first_page,
    output logic [ffra_pkg::OFF_W-1:0]       o_last_page,
    output logic [ffra_pkg::SIZE_W-1:0]      o_bytes_in_use
);
    import ffra_pkg::*;

    localparam int FIDX_W = $clog2(FREE_SLOTS);
    localparam int LIDX_W = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;

    logic [OFF_W-1:0]  r_fstart [FREE_SLOTS];
    logic [SIZE_W-1:0] r_flen   [FREE_SLOTS];
    logic [FREE_SLOTS-1:0] r_fvalid;
    logic [OFF_W-1:0]  r_lstart [LIVE_SLOTS];
    logic [SIZE_W-1:0] r_llen   [LIVE_SLOTS];
    logic [LIVE_SLOTS-1:0] r_lvalid;
    logic [SIZE_W-1:0] r_bytes;

    logic [CFG_W-1:0]  r_page;
    logic [CFG_W-1:0]  r_frames;
    logic [LIM_W-1:0]  r_limit;

    logic              r_is_free;
    logic [OFF_W-1:0]  r_off;
    logic [SIZE_W-1:0] r_size;
    logic [FIDX_W-1:0] r_fidx;
    logic [LIDX_W-1:0] r_lidx;
    logic              r_hit;
    logic [LIDX_W-1:0] r_hit_idx;
    logic              r_best;
    logic [FIDX_W-1:0] r_best_idx;
    logic [SIZE_W-1:0] r_best_len;
    logic              r_lo;
    logic [FIDX_W-1:0] r_lo_idx;
    logic [SIZE_W-1:0] r_lo_len;
    logic              r_hi;
    logic [FIDX_W-1:0] r_hi_idx;
    logic [SIZE_W-1:0] r_hi_len;
    logic              r_empty;
    logic [FIDX_W-1:0] r_empty_idx;
    logic [OFF_W-1:0]  r_first;
    logic [OFF_W-1:0]  r_last;

    logic              r_valid;
    t_status           r_status;
    logic [OFF_W-1:0]  r_gout;
    logic [OFF_W-1:0]  r_fpout;
    logic [OFF_W-1:0]  r_lpout;
    logic [SIZE_W-1:0] r_bout;

    logic [CFG_W-1:0]  n_eff_page;
    logic              n_arena_wr;
    logic [SIZE_W-1:0] n_arena_len;
    logic [OFF_W-1:0]  n_s;
    logic [SIZE_W-1:0] n_l;
    logic              n_v;
    logic              n_fit;
    logic              n_lo_match;
    logic              n_hi_match;
    logic              n_lmatch;
    logic [LIDX_W-1:0] n_lslot;
    logic [OFF_W-1:0]  n_end;
    logic [OFF_W-1:0]  n_dividend;
    logic [OFF_W-1:0]  n_quo;
    logic              n_div_done;
    logic [SIZE_W-1:0] n_bytes;

    always_comb begin
        n_eff_page  = (r_page == '0) ? CFG_W'(1) : r_page;
        n_arena_wr  = i_cfg_we && (i_cfg_idx == CFG_ARENA);
        n_arena_len = (i_cfg_wdata > ARENA_CAP) ? ARENA_CAP : i_cfg_wdata;
        n_s         = r_fstart[r_fidx];
        n_l         = r_flen[r_fidx];
        n_v         = r_fvalid[r_fidx];
        n_fit       = n_v && (n_l >= r_size) && (!r_best || (n_s < r_off));
        n_lo_match  = ({2'b0, n_s} + {1'b0, n_l}) == {2'b0, r_off};
        n_hi_match  = {2'b0, n_s} == ({2'b0, r_off} + {1'b0, r_size});
        n_lmatch    = r_lvalid[r_lidx] && (r_lstart[r_lidx] == r_off) && !r_hit;
        n_end       = OFF_W'({1'b0, r_off} + r_size - SIZE_W'(1));
        n_dividend  = i_ctl.div_last ? n_end : r_off;
        n_bytes     = r_is_free ? (r_bytes - r_size) : (r_bytes + r_size);
        n_lslot     = '0;
        for (int i = LIVE_SLOTS - 1; i >= 0; i--) begin
            if (!r_lvalid[i]) n_lslot = LIDX_W'(i);
        end
    end

    ffra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_eff_page),
        .o_quotient (n_quo),
        .o_done     (n_div_done)
    );

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page   <= RST_PAGE;
            r_frames <= RST_FRAMES;
            r_fvalid <= FREE_SLOTS'(1);
            r_lvalid <= '0;
            r_bytes  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_ctl.commit || i_ctl.emit_err;
            if (i_cfg_we && i_cfg_idx == CFG_PAGE) r_page <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_idx == CFG_FRAMES) r_frames <= i_cfg_wdata;
            if (n_arena_wr) begin
                r_fvalid <= FREE_SLOTS'(n_arena_len != '0);
                r_lvalid <= '0;
                r_bytes  <= '0;
            end else if (i_ctl.commit) begin
                r_bytes <= n_bytes;
                if (r_is_free) begin
                    r_lvalid[r_hit_idx] <= 1'b0;
                    if (r_lo && r_hi) r_fvalid[r_hi_idx] <= 1'b0;
                    else if (!r_lo && !r_hi) r_fvalid[r_empty_idx] <= 1'b1;
                end else begin
                    r_lvalid[n_lslot] <= 1'b1;
                    if (r_best_len <= r_size) r_fvalid[r_best_idx] <= 1'b0;
                end
            end
        end
    end

    // range tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstart[0] <= '0;
            r_flen[0]   <= ARENA_CAP;
        end else if (n_arena_wr) begin
            r_fstart[0] <= '0;
            r_flen[0]   <= n_arena_len;
        end else if (i_ctl.commit) begin
            if (r_is_free) begin
                if (r_lo && r_hi) begin
                    r_flen[r_lo_idx] <= r_lo_len + r_size + r_hi_len;
                end else if (r_lo) begin
                    r_flen[r_lo_idx] <= r_lo_len + r_size;
                end else if (r_hi) begin
                    r_fstart[r_hi_idx] <= r_off;
                    r_flen[r_hi_idx]   <= r_hi_len + r_size;
                end else begin
                    r_fstart[r_empty_idx] <= r_off;
                    r_flen[r_empty_idx]   <= r_size;
                end
            end else begin
                r_lstart[n_lslot] <= r_off;
                r_llen[n_lslot]   <= r_size;
                if (r_best_len > r_size) begin
                    r_fstart[r_best_idx] <= OFF_W'({1'b0, r_off} + r_size);
                    r_flen[r_best_idx]   <= r_best_len - r_size;
                end
            end
        end
    end

    // request registers and scan state
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_is_free <= i_cmd;
            r_off     <= i_block_offset;
            r_size    <= i_request_size;
            r_fidx    <= '0;
            r_lidx    <= '0;
            r_hit     <= 1'b0;
            r_best    <= 1'b0;
            r_lo      <= 1'b0;
            r_hi      <= 1'b0;
            r_empty   <= 1'b0;
        end
        if (i_ctl.load_limit) r_limit <= r_frames * n_eff_page;
        if (i_ctl.lscan_step) begin
            r_lidx <= r_lidx + LIDX_W'(1);
            if (n_lmatch) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_lidx;
                r_size    <= r_llen[r_lidx];
            end
        end
        if (i_ctl.fscan_step) begin
            r_fidx <= r_fidx + FIDX_W'(1);
            if (!r_is_free) begin
                if (n_fit) begin
                    r_best     <= 1'b1;
                    r_best_idx <= r_fidx;
                    r_best_len <= n_l;
                    r_off      <= n_s;
                end
            end else if (n_v) begin
                if (n_lo_match) begin
                    r_lo     <= 1'b1;
                    r_lo_idx <= r_fidx;
                    r_lo_len <= n_l;
                end
                if (n_hi_match) begin
                    r_hi     <= 1'b1;
                    r_hi_idx <= r_fidx;
                    r_hi_len <= n_l;
                end
            end else if (!r_empty) begin
                r_empty     <= 1'b1;
                r_empty_idx <= r_fidx;
            end
        end
        if (n_div_done) begin
            if (i_ctl.div_last) r_last <= n_quo;
            else r_first <= n_quo;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_status <= ST_OK;
            r_gout   <= r_off;
            r_fpout  <= r_first;
            r_lpout  <= r_last;
            r_bout   <= n_bytes;
        end else if (i_ctl.emit_err) begin
            r_status <= i_ctl.err_code;
            r_gout   <= '0;
            r_fpout  <= '0;
            r_lpout  <= '0;
            r_bout   <= r_bytes;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.is_free    = r_is_free;
        o_sts.size_zero  = (r_size == '0);
        o_sts.too_many   = {{(LIM_W-SIZE_W){1'b0}}, r_size} > r_limit;
        o_sts.lscan_last = (r_lidx == LIDX_W'(LIVE_SLOTS - 1));
        o_sts.fscan_last = (r_fidx == FIDX_W'(FREE_SLOTS - 1));
        o_sts.hit        = r_hit;
        o_sts.best       = r_best;
        o_sts.live_full  = &r_lvalid;
        o_sts.merge_ok   = r_lo || r_hi || r_empty;
        o_sts.div_done   = n_div_done;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_granted_offset = r_gout;
    assign o_first_page     = r_fpout;
    assign o_last_page      = r_lpout;
    assign o_bytes_in_use   = r_bout;

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= ARENA_CAP)
        else $error("live byte count beyond arena");

endmodule
`default_nettype wire

[rtl/first_fit_range_allocator.sv]
// top level of the first-fit range allocator
`default_nettype none
// One request is taken when start is high and busy low. The slot tables are scanned one
// entry a cycle, and the first and last page numbers come from a shared 16-step divider,
// one after the other. The result word follows in the first cycle with busy low, marked
// by o_valid for that one cycle, and cannot be held off. Refused requests answer as soon
// as the check that refuses them is done.
module first_fit_range_allocator #(
    parameter int FREE_SLOTS = ffra_pkg::FREE_SLOTS_DEF,
    parameter int LIVE_SLOTS = ffra_pkg::LIVE_SLOTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_cmd,
    input  wire logic [ffra_pkg::SIZE_W-1:0] i_request_size,
    input  wire logic [ffra_pkg::OFF_W-1:0]  i_block_offset,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [ffra_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                             o_valid,
    output logic [2:0]                       o_status,
    output logic [ffra_pkg::OFF_W-1:0]       o_granted_offset,
    output logic [ffra_pkg::OFF_W-1:0]       o_first_page,
    output logic [ffra_pkg::OFF_W-1:0]       o_last_page,
    output logic [ffra_pkg::SIZE_W-1:0]      o_bytes_in_use
);
    import ffra_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    ffra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    ffra_dp #(
        .FREE_SLOTS (FREE_SLOTS),
        .LIVE_SLOTS (LIVE_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_cmd            (i_cmd),
        .i_request_size   (i_request_size),
        .i_block_offset   (i_block_offset),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_granted_offset (o_granted_offset),
        .o_first_page     (o_first_page),
        .o_last_page      (o_last_page),
        .o_bytes_in_use   (o_bytes_in_use)
    );

endmodule
`default_nettype wire
